/* rtl/mtdt_pkg.sv */
package mtdt_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam int OP_W       = 2;
   localparam int SEL_W      = 4;
   localparam int TIME_W     = 64;
   localparam int PERIOD_W   = 32;
   localparam int KIND_W     = 3;
   localparam int SLOT_NUM_W = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SUMMARY   = 3'd4;

   localparam logic [TIME_W-1:0] TIME_NONE = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_SCAN,
      ST_SUMMARY
   } mtdt_state_type;

endpackage

/* rtl/mtdt_stream_if.sv */
interface mtdt_req_if;
   logic                               valid;
   logic                               ready;
   logic [mtdt_pkg::OP_W-1:0]          operation;
   logic [mtdt_pkg::SEL_W-1:0]         slot_select;
   logic [mtdt_pkg::TIME_W-1:0]        first_deadline;
   logic [mtdt_pkg::PERIOD_W-1:0]      rearm_period;
   logic [mtdt_pkg::TIME_W-1:0]        current_time;

   modport source (
      output valid, operation, slot_select, first_deadline, rearm_period, current_time,
      input  ready
   );
   modport sink (
      input  valid, operation, slot_select, first_deadline, rearm_period, current_time,
      output ready
   );
endinterface

interface mtdt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mtdt_pkg::KIND_W-1:0]        kind;
   logic [mtdt_pkg::SLOT_NUM_W-1:0]    slot_number;
   logic [mtdt_pkg::TIME_W-1:0]        earliest_deadline;
   logic                               last_of_run;

   modport source (
      output valid, kind, slot_number, earliest_deadline, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, kind, slot_number, earliest_deadline, last_of_run,
      output ready
   );
endinterface

/* rtl/multi_timer_deadline_table.sv */
// Timer deadline table: SLOT_COUNT slots, each with a 64-bit absolute deadline,
// a 32-bit rearm period (0 = one-shot) and a valid bit cleared at reset. A submit
// claims the lowest free slot and answers with its number or with "table full";
// a cancel frees its slot if in range and always answers. A tick carrying the
// current time walks the slots from 0 upward and emits one fire item per due
// slot, in slot order; a periodic slot advances its deadline by its period
// (wrapping modulo 2^64), a one-shot slot is freed. The tick closes with a summary
// item carrying the earliest deadline still pending, all ones if the table is
// empty; last_of_run marks the final item of every request. One request is
// handled at a time: a submit or cancel loads its item into the output register
// once it is free and then returns to idle. A tick scans every slot, loads its
// summary item once the pipeline has drained and the output register is free,
// and then returns to idle. The scan is set by the single read port of the slot
// memory, which returns one slot per cycle while no fire item stalls the scan;
// the rest of a tick fills and drains the read, compare and minimum stages and
// loads the summary. A fire, summary or single item that waits for the consumer
// to drain the output register holds up the run until it can be loaded.
module multi_timer_deadline_table #(
   parameter int SLOT_COUNT = mtdt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mtdt_req_if.sink   req_ch,
   mtdt_rsp_if.source rsp_ch
);
   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int TIME_W  = mtdt_pkg::TIME_W;
   localparam int PER_W   = mtdt_pkg::PERIOD_W;
   localparam int ENTRY_W = TIME_W + PER_W;

   // ------------------------------------------------------------------
   // Request capture: hold the accepted item for the whole run.
   // ------------------------------------------------------------------
   mtdt_pkg::mtdt_state_type     state_ff, state_in;
   logic                         req_accept;
   logic [mtdt_pkg::OP_W-1:0]    op_ff;
   logic [mtdt_pkg::SEL_W-1:0]   sel_ff;
   logic [TIME_W-1:0]            dl_ff;
   logic [PER_W-1:0]             per_ff;
   logic [TIME_W-1:0]            now_ff;

   assign req_ch.ready = (state_ff == mtdt_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_ch.operation;
         sel_ff <= req_ch.slot_select;
         dl_ff  <= req_ch.first_deadline;
         per_ff <= req_ch.rearm_period;
         now_ff <= req_ch.current_time;
      end
   end

   // ------------------------------------------------------------------
   // Slot storage: deadline and period share one memory word; the valid
   // bits live in flops so reset clears them at once.
   // ------------------------------------------------------------------
   logic [SLOT_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic                  ram_re;
   logic [SLOT_W-1:0]     ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;

   mtdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Lowest free slot for a submit.
   logic              free_any;
   logic [SLOT_W-1:0] free_idx;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Cancel target; out-of-range selects leave the table untouched.
   logic              cancel_in_range;
   logic [SLOT_W-1:0] cancel_idx;

   assign cancel_in_range = (32'(sel_ff) < 32'(SLOT_COUNT));
   assign cancel_idx      = SLOT_W'(sel_ff);

   // ------------------------------------------------------------------
   // Output register: parts the scan from the consumer.
   // ------------------------------------------------------------------
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mtdt_pkg::KIND_W-1:0]       rsp_kind_ff;
   logic [mtdt_pkg::SLOT_NUM_W-1:0]   rsp_slot_ff;
   logic [TIME_W-1:0]                 rsp_earliest_ff;
   logic                              rsp_last_ff;
   logic                              out_free;
   logic                              out_load;
   logic [mtdt_pkg::KIND_W-1:0]       out_kind;
   logic [mtdt_pkg::SLOT_NUM_W-1:0]   out_slot;
   logic [TIME_W-1:0]                 out_earliest;
   logic                              out_last;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // ------------------------------------------------------------------
   // Scan pipeline.
   //   read:  issue slot scan_addr to the memory
   //   eval:  s1 holds the slot whose word sits in the read register;
   //          compare against now, rearm or free, emit the fire item
   //   min:   s2 holds the surviving deadline, folded into earliest
   // A fire item that finds the output register full stalls read and eval.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              scan_done;
   logic              issue;
   logic              s1_valid_ff, s1_valid_in;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [TIME_W-1:0] s1_dl;
   logic [PER_W-1:0]  s1_per;
   logic              s1_live;
   logic              s1_due;
   logic [TIME_W-1:0] s1_sum;
   logic              stall;
   logic              s2_valid_ff, s2_valid_in;
   logic [TIME_W-1:0] s2_dl_ff, s2_dl_in;
   logic [TIME_W-1:0] earliest_ff, earliest_in;

   assign s1_dl   = ram_rdata[ENTRY_W-1:PER_W];
   assign s1_per  = ram_rdata[PER_W-1:0];
   assign s1_live = slot_valid_ff[s1_slot_ff];
   assign s1_due  = s1_live && (s1_dl <= now_ff);
   assign s1_sum  = s1_dl + TIME_W'(s1_per);
   assign stall   = s1_valid_ff && s1_due && !out_free;

   assign scan_done = (scan_addr_ff == CNT_W'(SLOT_COUNT));
   assign issue     = (state_ff == mtdt_pkg::ST_SCAN) && !scan_done && !stall;
   assign ram_re    = issue;
   assign ram_raddr = scan_addr_ff[SLOT_W-1:0];

   assign s1_valid_in = stall ? s1_valid_ff : issue;
   // A freed one-shot slot and an empty slot drop out of the minimum.
   assign s2_valid_in = s1_valid_ff && !stall && s1_live && !(s1_due && (s1_per == '0));
   assign s2_dl_in    = s1_due ? s1_sum : s1_dl;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (req_accept) begin
         scan_addr_in = '0;
      end else if (issue) begin
         scan_addr_in = scan_addr_ff + CNT_W'(1);
      end
   end

   always_comb begin
      earliest_in = earliest_ff;
      if (req_accept) begin
         earliest_in = mtdt_pkg::TIME_NONE;
      end else if (s2_valid_ff && (s2_dl_ff < earliest_ff)) begin
         earliest_in = s2_dl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_slot_ff <= ram_raddr;
      end
      s2_dl_ff    <= s2_dl_in;
      earliest_ff <= earliest_in;
   end

   // ------------------------------------------------------------------
   // Sequencer: next state, table updates and output loads.
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      out_load      = 1'b0;
      out_kind      = mtdt_pkg::KIND_ACCEPTED;
      out_slot      = '0;
      out_earliest  = '0;
      out_last      = 1'b0;

      case (state_ff)
         mtdt_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.operation)
                  mtdt_pkg::OP_SUBMIT: state_in = mtdt_pkg::ST_SINGLE;
                  mtdt_pkg::OP_CANCEL: state_in = mtdt_pkg::ST_SINGLE;
                  mtdt_pkg::OP_TICK:   state_in = mtdt_pkg::ST_SCAN;
                  default:             state_in = mtdt_pkg::ST_IDLE;
               endcase
            end
         end

         mtdt_pkg::ST_SINGLE: begin
            // Hold the update until the answer can be loaded.
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               state_in = mtdt_pkg::ST_IDLE;
               if (op_ff == mtdt_pkg::OP_SUBMIT) begin
                  if (free_any) begin
                     out_kind                = mtdt_pkg::KIND_ACCEPTED;
                     out_slot                = mtdt_pkg::SLOT_NUM_W'(free_idx);
                     slot_valid_in[free_idx] = 1'b1;
                     ram_we                  = 1'b1;
                     ram_waddr               = free_idx;
                     ram_wdata               = {dl_ff, per_ff};
                  end else begin
                     out_kind = mtdt_pkg::KIND_FULL;
                  end
               end else begin
                  out_kind = mtdt_pkg::KIND_CANCELLED;
                  out_slot = sel_ff;
                  if (cancel_in_range) begin
                     slot_valid_in[cancel_idx] = 1'b0;
                  end
               end
            end
         end

         mtdt_pkg::ST_SCAN: begin
            if (s1_valid_ff && s1_due && out_free) begin
               out_load = 1'b1;
               out_kind = mtdt_pkg::KIND_FIRED;
               out_slot = mtdt_pkg::SLOT_NUM_W'(s1_slot_ff);
               if (s1_per == '0) begin
                  slot_valid_in[s1_slot_ff] = 1'b0;
               end else begin
                  // Rearm from the old deadline, not from now: no drift.
                  ram_we    = 1'b1;
                  ram_waddr = s1_slot_ff;
                  ram_wdata = {s1_sum, s1_per};
               end
            end
            if (scan_done && !s1_valid_ff && !s2_valid_ff) begin
               state_in = mtdt_pkg::ST_SUMMARY;
            end
         end

         mtdt_pkg::ST_SUMMARY: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_kind     = mtdt_pkg::KIND_SUMMARY;
               out_earliest = earliest_ff;
               out_last     = 1'b1;
               state_in     = mtdt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mtdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtdt_pkg::ST_IDLE;
         slot_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff     <= out_kind;
         rsp_slot_ff     <= out_slot;
         rsp_earliest_ff <= out_earliest;
         rsp_last_ff     <= out_last;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.kind              = rsp_kind_ff;
   assign rsp_ch.slot_number       = rsp_slot_ff;
   assign rsp_ch.earliest_deadline = rsp_earliest_ff;
   assign rsp_ch.last_of_run       = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A stalled fire holds its slot in the eval stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && $stable(s1_slot_ff))
      else $error("eval stage lost a stalled slot");

   // The scan only writes back a slot that is still live.
   a_rearm_live: assert property (@(posedge clock) disable iff (reset)
      ram_we && (state_ff == mtdt_pkg::ST_SCAN) |-> slot_valid_ff[s1_slot_ff])
      else $error("rearm written to a free slot");

   // The scan pointer never passes the table end.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_addr_ff <= CNT_W'(SLOT_COUNT))
      else $error("scan pointer out of range");

   // The pipeline is empty whenever a new request can be taken.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtdt_pkg::ST_IDLE) |-> !s1_valid_ff && !s2_valid_ff)
      else $error("scan pipeline busy while idle");

   // A summary leaves the sequencer idle on the next cycle.
   a_summary_ends: assert property (@(posedge clock) disable iff (reset)
      out_load && (out_kind == mtdt_pkg::KIND_SUMMARY) |=> (state_ff == mtdt_pkg::ST_IDLE))
      else $error("run continued past its summary");

endmodule

/* rtl/mtdt_ram.sv */
module mtdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
